// ===== hw/rtl/optical_flow_frame_parser_macros.svh =====
// Assertion macros for the optical flow frame parser.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef OPTICAL_FLOW_FRAME_PARSER_MACROS_SVH
`define OPTICAL_FLOW_FRAME_PARSER_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define OFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent on one edge implies consequent on the next edge.
`define OFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ofp_pkg.sv =====
// Shared types and constants for the optical flow frame parser.
// No dependencies.
package ofp_pkg;

  localparam logic [7:0] HdrByte    = 8'hFE;
  localparam logic [7:0] LenByte    = 8'h0A;
  localparam logic [7:0] TailByte   = 8'h55;
  localparam int unsigned PayloadLen = 10;
  localparam int unsigned PhaseW     = 4;
  localparam int unsigned IdxW       = $clog2(PayloadLen);

  localparam logic [PhaseW-1:0] PhHeader   = 4'd0;
  localparam logic [PhaseW-1:0] PhLength   = 4'd1;
  localparam logic [PhaseW-1:0] PhPayload0 = 4'd2;
  localparam logic [PhaseW-1:0] PhCheck    = 4'd12;
  localparam logic [PhaseW-1:0] PhTail     = 4'd13;

  // Packed so that flow_x sits in the lowest bits.
  typedef struct packed {
    logic [7:0]         version_byte;
    logic [7:0]         valid_byte;
    logic [15:0]        gnd_range;
    logic [15:0]        integration_time;
    logic signed [15:0] flow_y;
    logic signed [15:0] flow_x;
  } frame_data_t;

  localparam int unsigned DataW = $bits(frame_data_t);

  typedef struct packed {
    logic        frame_done;
    frame_data_t data;
  } result_t;

endpackage

// ===== hw/rtl/ofp_core.sv =====
// Frame tracking state, payload store and checksum of the frame parser.
// Depends on ofp_pkg.
module ofp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [7:0]                    rx_byte_i,
  output ofp_pkg::result_t              res_o,
  output logic [ofp_pkg::PhaseW-1:0]    phase_o
);

  logic [ofp_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [7:0]                 xor_q, xor_d;
  logic [7:0]                 store_q [ofp_pkg::PayloadLen];
  logic                       store_we;
  logic [ofp_pkg::PhaseW-1:0] idx_full;
  logic [ofp_pkg::IdxW-1:0]   store_idx;
  logic                       done;

  assign idx_full  = phase_q - ofp_pkg::PhPayload0;
  assign store_idx = idx_full[ofp_pkg::IdxW-1:0];

  always_comb begin
    phase_d  = phase_q;
    xor_d    = xor_q;
    store_we = 1'b0;
    done     = 1'b0;
    priority if (phase_q == ofp_pkg::PhHeader && rx_byte_i == ofp_pkg::HdrByte) begin
      phase_d = ofp_pkg::PhLength;
    end else if (phase_q == ofp_pkg::PhLength && rx_byte_i == ofp_pkg::LenByte) begin
      phase_d = ofp_pkg::PhPayload0;
      xor_d   = '0;
    end else if (phase_q >= ofp_pkg::PhPayload0 && phase_q < ofp_pkg::PhCheck) begin
      phase_d  = phase_q + 1'b1;
      xor_d    = xor_q ^ rx_byte_i;
      store_we = 1'b1;
    end else if (phase_q == ofp_pkg::PhCheck) begin
      phase_d = (xor_q == rx_byte_i) ? ofp_pkg::PhTail : ofp_pkg::PhHeader;
    end else if (phase_q == ofp_pkg::PhTail) begin
      phase_d = ofp_pkg::PhHeader;
      done    = (rx_byte_i == ofp_pkg::TailByte);
    end else begin
      phase_d = ofp_pkg::PhHeader;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ofp_pkg::PhHeader;
      xor_q   <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && store_we) begin
      store_q[store_idx] <= rx_byte_i;
    end
  end

  always_comb begin
    res_o            = '0;
    res_o.frame_done = done;
    if (done) begin
      res_o.data.flow_x           = {store_q[1], store_q[0]};
      res_o.data.flow_y           = {store_q[3], store_q[2]};
      res_o.data.integration_time = {store_q[5], store_q[4]};
      res_o.data.gnd_range        = {store_q[7], store_q[6]};
      res_o.data.valid_byte       = store_q[8];
      res_o.data.version_byte     = store_q[9];
    end
  end

  assign phase_o = phase_q;

endmodule

// ===== hw/rtl/optical_flow_frame_parser.sv =====
// Top level of the optical flow frame parser: stream ports and result register.
// Depends on ofp_pkg, ofp_core and optical_flow_frame_parser_macros.svh.
//
// Takes one received serial byte per beat and returns one result beat per
// input beat, in order. A beat is accepted every cycle while the result
// register is empty or being drained; the registered result appears in the
// cycle after acceptance. tuser is high on the beat whose byte completed a good
// 14-byte frame (0xFE, 0x0A, ten payload bytes, XOR checksum, 0x55); then
// tdata carries the decoded payload, otherwise tdata is zero.
`include "optical_flow_frame_parser_macros.svh"

module optical_flow_frame_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] rx_byte
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [15:0] flow_x, [31:16] flow_y, [47:32] integration_time,
  // [63:48] gnd_range, [71:64] valid_byte, [79:72] version_byte
  output logic [ofp_pkg::DataW-1:0]  m_axis_tdata,
  output logic                       m_axis_tuser   // [0] frame_done
);

  logic                       in_beat;
  ofp_pkg::result_t           res;
  logic [ofp_pkg::PhaseW-1:0] phase;
  logic                       out_valid_q;
  ofp_pkg::result_t           out_q;
  logic                       good_tail;
  logic                       done_beat;
  logic                       idle_beat;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  ofp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (in_beat),
    .rx_byte_i (s_axis_tdata),
    .res_o     (res),
    .phase_o   (phase)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tuser  = out_q.frame_done;

  assign good_tail = in_beat && phase == ofp_pkg::PhTail &&
                     s_axis_tdata == ofp_pkg::TailByte;
  assign done_beat = m_axis_tvalid && m_axis_tuser;
  assign idle_beat = m_axis_tvalid && !m_axis_tuser;

  `OFP_ASSERT(a_phase_range, phase <= ofp_pkg::PhTail, "frame phase out of range")
  `OFP_ASSERT(a_zero_when_not_done, !idle_beat || m_axis_tdata == '0, "tdata set without done")
  `OFP_ASSERT_NEXT(a_good_tail, good_tail, done_beat && phase == ofp_pkg::PhHeader, "tail lost")
  `OFP_ASSERT_NEXT(a_done_from_tail, in_beat && phase != ofp_pkg::PhTail, !m_axis_tuser, "done early")

endmodule

// ===== verif/tb_optical_flow_frame_parser.sv =====
// Testbench for optical_flow_frame_parser: drives serial bytes as stream beats and checks
// every result beat against a local frame decoder, under random bursts and output stalls.
// Depends on ofp_pkg and the optical_flow_frame_parser RTL.
module tb_optical_flow_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumFrameBytes = 1950;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned DrainCycles   = 8;

  typedef enum int {
    FrGood,
    FrBadSum,
    FrBadTail,
    FrBadLen,
    FrShort
  } frame_kind_e;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [ofp_pkg::DataW-1:0] m_axis_tdata;
  logic                      m_axis_tuser;

  optical_flow_frame_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [7:0]       rx_bytes_q[$];
  ofp_pkg::result_t frame_results_q[$];
  int unsigned      fail_count  = 0;
  int unsigned      frame_bytes = 0;
  int unsigned      cycles      = 0;
  logic             in_taken    = 1'b0;

  // Decoder state
  logic [ofp_pkg::PhaseW-1:0] parse_phase = ofp_pkg::PhHeader;
  logic [7:0]                 payload_bytes [ofp_pkg::PayloadLen];
  logic [7:0]                 payload_xor = '0;

  function automatic ofp_pkg::result_t parse_byte(input logic [7:0] b);
    ofp_pkg::result_t r;
    r = '0;
    if (parse_phase == ofp_pkg::PhHeader && b == ofp_pkg::HdrByte) begin
      parse_phase = ofp_pkg::PhLength;
    end else if (parse_phase == ofp_pkg::PhLength && b == ofp_pkg::LenByte) begin
      parse_phase = ofp_pkg::PhPayload0;
      payload_xor = '0;
    end else if (parse_phase >= ofp_pkg::PhPayload0 && parse_phase < ofp_pkg::PhCheck) begin
      payload_bytes[parse_phase - ofp_pkg::PhPayload0] = b;
      payload_xor = payload_xor ^ b;
      parse_phase = parse_phase + 1'b1;
    end else if (parse_phase == ofp_pkg::PhCheck) begin
      parse_phase = (payload_xor == b) ? ofp_pkg::PhTail : ofp_pkg::PhHeader;
    end else if (parse_phase == ofp_pkg::PhTail) begin
      parse_phase = ofp_pkg::PhHeader;
      if (b == ofp_pkg::TailByte) begin
        r.frame_done            = 1'b1;
        r.data.flow_x           = {payload_bytes[1], payload_bytes[0]};
        r.data.flow_y           = {payload_bytes[3], payload_bytes[2]};
        r.data.integration_time = {payload_bytes[5], payload_bytes[4]};
        r.data.gnd_range        = {payload_bytes[7], payload_bytes[6]};
        r.data.valid_byte       = payload_bytes[8];
        r.data.version_byte     = payload_bytes[9];
      end
    end else begin
      parse_phase = ofp_pkg::PhHeader;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: checks result beats, predicts on accepted input beats
  always @(posedge clk_i) begin : monitor
    ofp_pkg::result_t     want;
    ofp_pkg::frame_data_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = ofp_pkg::frame_data_t'(m_axis_tdata);
        if (frame_results_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual tuser %b tdata %h",
                   $time, m_axis_tuser, m_axis_tdata);
          fail_count++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("frame_done", 16'(want.frame_done), 16'(m_axis_tuser));
          check_field("flow_x", want.data.flow_x, got.flow_x);
          check_field("flow_y", want.data.flow_y, got.flow_y);
          check_field("integration_time", want.data.integration_time, got.integration_time);
          check_field("gnd_range", want.data.gnd_range, got.gnd_range);
          check_field("valid_byte", 16'(want.data.valid_byte), 16'(got.valid_byte));
          check_field("version_byte", 16'(want.data.version_byte), 16'(got.version_byte));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        frame_results_q.push_back(parse_byte(s_axis_tdata));
      end
    end
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // Driver: bursts of beats with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (rx_bytes_q.size() > 0) begin
        s_axis_tdata  <= rx_bytes_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall mode is chosen at random from four modes
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(16, 200);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("optical_flow_frame_parser verification failed");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    frame_bytes++;
  endtask

  task automatic add_frame(input logic [7:0] pl [ofp_pkg::PayloadLen],
                           input frame_kind_e kind);
    logic [7:0] sum;
    logic [7:0] bad;
    int unsigned cut;
    sum = '0;
    add_byte(ofp_pkg::HdrByte);
    if (kind == FrBadLen) begin
      bad = 8'($urandom_range(0, 255));
      if (bad == ofp_pkg::LenByte) bad = bad ^ 8'h01;
      add_byte(bad);
      return;
    end
    add_byte(ofp_pkg::LenByte);
    cut = (kind == FrShort) ? $urandom_range(0, ofp_pkg::PayloadLen - 1) : ofp_pkg::PayloadLen;
    for (int i = 0; i < cut; i++) begin
      add_byte(pl[i]);
      sum = sum ^ pl[i];
    end
    if (kind == FrShort) return;
    add_byte((kind == FrBadSum) ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    if (kind == FrBadTail) begin
      bad = 8'($urandom_range(0, 255));
      if (bad == ofp_pkg::TailByte) bad = bad ^ 8'h01;
      add_byte(bad);
    end else begin
      add_byte(ofp_pkg::TailByte);
    end
  endtask

  initial begin : stimulus
    logic [7:0]  pl [ofp_pkg::PayloadLen];
    int unsigned pick;
    frame_kind_e kind;

    // Directed: stray byte, bad length, header as length, then an extreme good frame
    add_byte(8'h07);
    add_byte(ofp_pkg::HdrByte);
    add_byte(8'h00);
    add_byte(ofp_pkg::HdrByte);
    add_byte(ofp_pkg::HdrByte);
    pl = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF};
    add_frame(pl, FrGood);

    while (frame_bytes < NumFrameBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        repeat ($urandom_range(1, 6)) begin
          add_byte(($urandom_range(0, 3) == 0) ? ofp_pkg::HdrByte
                                               : 8'($urandom_range(0, 255)));
        end
      end else begin
        if (pick < 62)      kind = FrGood;
        else if (pick < 74) kind = FrBadSum;
        else if (pick < 86) kind = FrBadTail;
        else if (pick < 93) kind = FrBadLen;
        else                kind = FrShort;
        for (int i = 0; i < ofp_pkg::PayloadLen; i++) begin
          case ($urandom_range(0, 9))
            0:       pl[i] = 8'h00;
            1:       pl[i] = 8'hFF;
            2:       pl[i] = 8'h80;
            3:       pl[i] = 8'h7F;
            default: pl[i] = 8'($urandom_range(0, 255));
          endcase
        end
        add_frame(pl, kind);
      end
    end

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (rx_bytes_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("optical_flow_frame_parser verification clean");
    end else begin
      $display("optical_flow_frame_parser verification failed");
    end
    $finish;
  end

endmodule
